// File: sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int unsigned CoordWidth = 32;  // default coordinate width
  localparam int unsigned RatioFrac  = 32;  // fraction bits of a ratio

  typedef enum logic [2:0] {
    REG_A  = 3'd0,
    REG_B  = 3'd1,
    REG_AB = 3'd2,
    REG_C  = 3'd3,
    REG_AC = 3'd4,
    REG_BC = 3'd5,
    REG_IN = 3'd6
  } region_e;

  typedef enum logic [1:0] {
    RM_ZERO = 2'd0,
    RM_ONE  = 2'd1,
    RM_DIV  = 2'd2
  } ratio_mode_e;

  typedef struct packed {
    region_e     region;
    ratio_mode_e mode1;
    ratio_mode_e mode2;
  } ctl_t;

endpackage

// File: sv/cpt_dot.sv
// ----------------------------------------------------------------------------
// cpt_dot
// Edge and offset vectors, per-axis products and the six dot products.
// Three register stages.
// ----------------------------------------------------------------------------
module cpt_dot #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [COORD_WIDTH-1:0]  p_i  [3],
  input  logic signed [COORD_WIDTH-1:0]  a_i  [3],
  input  logic signed [COORD_WIDTH-1:0]  b_i  [3],
  input  logic signed [COORD_WIDTH-1:0]  c_i  [3],
  output logic                           valid_o,
  output logic signed [2*COORD_WIDTH+3:0] d_o [6],
  output logic signed [COORD_WIDTH-1:0]  a_o  [3],
  output logic signed [COORD_WIDTH-1:0]  b_o  [3],
  output logic signed [COORD_WIDTH-1:0]  c_o  [3],
  output logic signed [COORD_WIDTH:0]    ab_o [3],
  output logic signed [COORD_WIDTH:0]    ac_o [3],
  output logic signed [COORD_WIDTH:0]    bc_o [3]
);
  import cpt_pkg::*;

  localparam int unsigned W1 = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;
  localparam int unsigned DW = 2 * COORD_WIDTH + 4;

  // stage 1: differences
  logic                  v1_q;
  logic signed [W1-1:0]  ab1_q [3], ac1_q [3], bc1_q [3];
  logic signed [W1-1:0]  ap1_q [3], bp1_q [3], cp1_q [3];
  logic signed [COORD_WIDTH-1:0] a1_q [3], b1_q [3], c1_q [3];
  // stage 2: products
  logic                  v2_q;
  logic signed [PW-1:0]  pr2_q [6][3];
  logic signed [COORD_WIDTH-1:0] a2_q [3], b2_q [3], c2_q [3];
  logic signed [W1-1:0]  ab2_q [3], ac2_q [3], bc2_q [3];
  // stage 3: sums
  logic                  v3_q;
  logic signed [DW-1:0]  d3_q [6];
  logic signed [COORD_WIDTH-1:0] a3_q [3], b3_q [3], c3_q [3];
  logic signed [W1-1:0]  ab3_q [3], ac3_q [3], bc3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ab1_q[k] <= W1'(b_i[k]) - W1'(a_i[k]);
      ac1_q[k] <= W1'(c_i[k]) - W1'(a_i[k]);
      bc1_q[k] <= W1'(c_i[k]) - W1'(b_i[k]);
      ap1_q[k] <= W1'(p_i[k]) - W1'(a_i[k]);
      bp1_q[k] <= W1'(p_i[k]) - W1'(b_i[k]);
      cp1_q[k] <= W1'(p_i[k]) - W1'(c_i[k]);
      a1_q[k]  <= a_i[k];
      b1_q[k]  <= b_i[k];
      c1_q[k]  <= c_i[k];

      // order: ab.ap, ac.ap, ab.bp, ac.bp, ab.cp, ac.cp
      pr2_q[0][k] <= PW'(ab1_q[k]) * PW'(ap1_q[k]);
      pr2_q[1][k] <= PW'(ac1_q[k]) * PW'(ap1_q[k]);
      pr2_q[2][k] <= PW'(ab1_q[k]) * PW'(bp1_q[k]);
      pr2_q[3][k] <= PW'(ac1_q[k]) * PW'(bp1_q[k]);
      pr2_q[4][k] <= PW'(ab1_q[k]) * PW'(cp1_q[k]);
      pr2_q[5][k] <= PW'(ac1_q[k]) * PW'(cp1_q[k]);
      a2_q[k]  <= a1_q[k];
      b2_q[k]  <= b1_q[k];
      c2_q[k]  <= c1_q[k];
      ab2_q[k] <= ab1_q[k];
      ac2_q[k] <= ac1_q[k];
      bc2_q[k] <= bc1_q[k];

      a3_q[k]  <= a2_q[k];
      b3_q[k]  <= b2_q[k];
      c3_q[k]  <= c2_q[k];
      ab3_q[k] <= ab2_q[k];
      ac3_q[k] <= ac2_q[k];
      bc3_q[k] <= bc2_q[k];
    end
    for (int j = 0; j < 6; j++) begin
      d3_q[j] <= DW'(pr2_q[j][0]) + DW'(pr2_q[j][1]) + DW'(pr2_q[j][2]);
    end
  end

  assign valid_o = v3_q;
  assign d_o  = d3_q;
  assign a_o  = a3_q;
  assign b_o  = b3_q;
  assign c_o  = c3_q;
  assign ab_o = ab3_q;
  assign ac_o = ac3_q;
  assign bc_o = bc3_q;

endmodule

// File: sv/cpt_region.sv
// ----------------------------------------------------------------------------
// cpt_region
// Cross terms of the dot products, region select and divider setup.
// Three register stages.
// ----------------------------------------------------------------------------
module cpt_region #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [2*COORD_WIDTH+3:0] d_i  [6],
  input  logic signed [COORD_WIDTH-1:0]   a_i  [3],
  input  logic signed [COORD_WIDTH-1:0]   b_i  [3],
  input  logic signed [COORD_WIDTH-1:0]   c_i  [3],
  input  logic signed [COORD_WIDTH:0]     ab_i [3],
  input  logic signed [COORD_WIDTH:0]     ac_i [3],
  input  logic signed [COORD_WIDTH:0]     bc_i [3],
  output logic                            valid_o,
  output cpt_pkg::ctl_t                   ctl_o,
  output logic [4*COORD_WIDTH+11:0]       num1_o,
  output logic [4*COORD_WIDTH+11:0]       den1_o,
  output logic [4*COORD_WIDTH+11:0]       num2_o,
  output logic [4*COORD_WIDTH+11:0]       den2_o,
  output logic signed [COORD_WIDTH-1:0]   base_o [3],
  output logic signed [COORD_WIDTH:0]     dir1_o [3],
  output logic signed [COORD_WIDTH:0]     dir2_o [3]
);
  import cpt_pkg::*;

  localparam int unsigned W1 = COORD_WIDTH + 1;
  localparam int unsigned DW = 2 * COORD_WIDTH + 4;
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned XW = 4 * COORD_WIDTH + 12;
  localparam int unsigned HB = DW / 2;       // width of the low half
  localparam int unsigned PP = 2 * HB + 2;   // partial product width

  function automatic logic le0(input logic signed [XW-1:0] x);
    return x[XW-1] | ~|x;
  endfunction

  function automatic logic ge0(input logic signed [XW-1:0] x);
    return ~x[XW-1];
  endfunction

  function automatic ratio_mode_e rmode(input logic signed [XW-1:0] num,
                                        input logic signed [XW-1:0] den);
    ratio_mode_e m;
    if (le0(den) || le0(num)) begin
      m = RM_ZERO;
    end else if (num >= den) begin
      m = RM_ONE;
    end else begin
      m = RM_DIV;
    end
    return m;
  endfunction

  // operand pairs: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  logic signed [DW-1:0] xa [6], xb [6];

  always_comb begin
    xa[0] = d_i[0]; xb[0] = d_i[3];
    xa[1] = d_i[2]; xb[1] = d_i[1];
    xa[2] = d_i[4]; xb[2] = d_i[1];
    xa[3] = d_i[0]; xb[3] = d_i[5];
    xa[4] = d_i[2]; xb[4] = d_i[5];
    xa[5] = d_i[4]; xb[5] = d_i[3];
  end

  // stage 4: half-width partial products (low halves unsigned, high signed)
  logic                  v4_q;
  logic signed [PP-1:0]  pll4_q [6], plh4_q [6], phl4_q [6], phh4_q [6];
  logic signed [DW-1:0]  d4_q [6];
  logic signed [COORD_WIDTH-1:0] a4_q [3], b4_q [3], c4_q [3];
  logic signed [W1-1:0]  ab4_q [3], ac4_q [3], bc4_q [3];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      pll4_q[j] <= PP'($signed({1'b0, xa[j][HB-1:0]})) *
                   PP'($signed({1'b0, xb[j][HB-1:0]}));
      plh4_q[j] <= PP'($signed({1'b0, xa[j][HB-1:0]})) * PP'($signed(xb[j][DW-1:HB]));
      phl4_q[j] <= PP'($signed(xa[j][DW-1:HB])) * PP'($signed({1'b0, xb[j][HB-1:0]}));
      phh4_q[j] <= PP'($signed(xa[j][DW-1:HB])) * PP'($signed(xb[j][DW-1:HB]));
    end
    d4_q  <= d_i;
    a4_q  <= a_i;
    b4_q  <= b_i;
    c4_q  <= c_i;
    ab4_q <= ab_i;
    ac4_q <= ac_i;
    bc4_q <= bc_i;
  end

  // stage 5: full cross products
  logic                  v5_q;
  logic signed [MW-1:0]  m5_q [6];
  logic signed [DW-1:0]  d5_q [6];
  logic signed [COORD_WIDTH-1:0] a5_q [3], b5_q [3], c5_q [3];
  logic signed [W1-1:0]  ab5_q [3], ac5_q [3], bc5_q [3];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      m5_q[j] <= (MW'(phh4_q[j]) <<< (2 * HB)) +
                 ((MW'(plh4_q[j]) + MW'(phl4_q[j])) <<< HB) + MW'(pll4_q[j]);
    end
    d5_q  <= d4_q;
    a5_q  <= a4_q;
    b5_q  <= b4_q;
    c5_q  <= c4_q;
    ab5_q <= ab4_q;
    ac5_q <= ac4_q;
    bc5_q <= bc4_q;
  end

  logic signed [XW-1:0] dd [6];
  logic signed [XW-1:0] va, vb, vc, e1, e2, den_in;
  logic signed [XW-1:0] num1_d, den1_d, num2_d, den2_d;
  region_e              region_d;
  logic signed [COORD_WIDTH-1:0] base_d [3];
  logic signed [W1-1:0] dir1_d [3];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dd[j] = XW'(d5_q[j]);
    end
    vc     = XW'(m5_q[0]) - XW'(m5_q[1]);
    vb     = XW'(m5_q[2]) - XW'(m5_q[3]);
    va     = XW'(m5_q[4]) - XW'(m5_q[5]);
    e1     = dd[3] - dd[2];
    e2     = dd[4] - dd[5];
    den_in = va + vb + vc;

    num1_d = '0;
    den1_d = '0;
    num2_d = '0;
    den2_d = '0;
    base_d = a5_q;
    dir1_d = ab5_q;
    priority if (le0(dd[0]) && le0(dd[1])) begin
      region_d = REG_A;
    end else if (ge0(dd[2]) && (dd[3] <= dd[2])) begin
      region_d = REG_B;
      base_d   = b5_q;
    end else if (le0(vc) && ge0(dd[0]) && le0(dd[2])) begin
      region_d = REG_AB;
      num1_d   = dd[0];
      den1_d   = dd[0] - dd[2];
    end else if (ge0(dd[5]) && (dd[4] <= dd[5])) begin
      region_d = REG_C;
      base_d   = c5_q;
    end else if (le0(vb) && ge0(dd[1]) && le0(dd[5])) begin
      region_d = REG_AC;
      num2_d   = dd[1];
      den2_d   = dd[1] - dd[5];
    end else if (le0(va) && ge0(e1) && ge0(e2)) begin
      region_d = REG_BC;
      base_d   = b5_q;
      dir1_d   = bc5_q;
      num1_d   = e1;
      den1_d   = e1 + e2;
    end else begin
      region_d = REG_IN;
      // flat triangle: zero ratios leave vertex A
      if (!le0(den_in)) begin
        num1_d = vb;
        den1_d = den_in;
        num2_d = vc;
        den2_d = den_in;
      end
    end
  end

  logic                  v6_q;
  ctl_t                  ctl6_q;
  logic [XW-1:0]         num1_q, den1_q, num2_q, den2_q;
  logic signed [COORD_WIDTH-1:0] base6_q [3];
  logic signed [W1-1:0]  dir1_6_q [3], dir2_6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl6_q.region <= region_d;
    ctl6_q.mode1  <= rmode(num1_d, den1_d);
    ctl6_q.mode2  <= rmode(num2_d, den2_d);
    num1_q   <= num1_d;
    den1_q   <= den1_d;
    num2_q   <= num2_d;
    den2_q   <= den2_d;
    base6_q  <= base_d;
    dir1_6_q <= dir1_d;
    dir2_6_q <= ac5_q;
  end

  assign valid_o = v6_q;
  assign ctl_o   = ctl6_q;
  assign num1_o  = num1_q;
  assign den1_o  = den1_q;
  assign num2_o  = num2_q;
  assign den2_o  = den2_q;
  assign base_o  = base6_q;
  assign dir1_o  = dir1_6_q;
  assign dir2_o  = dir2_6_q;

endmodule

// File: sv/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// Two pipelined restoring dividers, one quotient bit per stage.
// Quotient = floor(num * 2^RatioFrac / den) for 0 < num < den.
// ----------------------------------------------------------------------------
module cpt_div #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  cpt_pkg::ctl_t                     ctl_i,
  input  logic [4*COORD_WIDTH+11:0]         num1_i,
  input  logic [4*COORD_WIDTH+11:0]         den1_i,
  input  logic [4*COORD_WIDTH+11:0]         num2_i,
  input  logic [4*COORD_WIDTH+11:0]         den2_i,
  input  logic signed [COORD_WIDTH-1:0]     base_i [3],
  input  logic signed [COORD_WIDTH:0]       dir1_i [3],
  input  logic signed [COORD_WIDTH:0]       dir2_i [3],
  output logic                              valid_o,
  output cpt_pkg::ctl_t                     ctl_o,
  output logic [cpt_pkg::RatioFrac-1:0]     q1_o,
  output logic [cpt_pkg::RatioFrac-1:0]     q2_o,
  output logic signed [COORD_WIDTH-1:0]     base_o [3],
  output logic signed [COORD_WIDTH:0]       dir1_o [3],
  output logic signed [COORD_WIDTH:0]       dir2_o [3]
);
  import cpt_pkg::*;

  localparam int unsigned W1 = COORD_WIDTH + 1;
  localparam int unsigned XW = 4 * COORD_WIDTH + 12;
  localparam int unsigned NS = RatioFrac;

  logic                  v_q    [NS];
  ctl_t                  ctl_q  [NS];
  logic [XW-1:0]         r1_q   [NS], r2_q [NS], dn1_q [NS], dn2_q [NS];
  logic [RatioFrac-1:0]  q1_q   [NS], q2_q [NS];
  logic signed [COORD_WIDTH-1:0] base_q [NS][3];
  logic signed [W1-1:0]  dir1_q [NS][3], dir2_q [NS][3];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                 v_in;
    ctl_t                 ctl_in;
    logic [XW-1:0]        r1_in, r2_in, dn1_in, dn2_in;
    logic [RatioFrac-1:0] q1_in, q2_in;
    logic signed [COORD_WIDTH-1:0] base_in [3];
    logic signed [W1-1:0] dir1_in [3], dir2_in [3];
    logic [XW-1:0]        s1, s2;
    logic                 ge1, ge2;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign ctl_in  = ctl_i;
      assign r1_in   = num1_i;
      assign r2_in   = num2_i;
      assign dn1_in  = den1_i;
      assign dn2_in  = den2_i;
      assign q1_in   = '0;
      assign q2_in   = '0;
      assign base_in = base_i;
      assign dir1_in = dir1_i;
      assign dir2_in = dir2_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign ctl_in  = ctl_q[i-1];
      assign r1_in   = r1_q[i-1];
      assign r2_in   = r2_q[i-1];
      assign dn1_in  = dn1_q[i-1];
      assign dn2_in  = dn2_q[i-1];
      assign q1_in   = q1_q[i-1];
      assign q2_in   = q2_q[i-1];
      assign base_in = base_q[i-1];
      assign dir1_in = dir1_q[i-1];
      assign dir2_in = dir2_q[i-1];
    end

    // remainder stays below den, so the doubled value fits
    assign s1  = {r1_in[XW-2:0], 1'b0};
    assign s2  = {r2_in[XW-2:0], 1'b0};
    assign ge1 = (s1 >= dn1_in);
    assign ge2 = (s2 >= dn2_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ctl_q[i]  <= ctl_in;
      r1_q[i]   <= ge1 ? s1 - dn1_in : s1;
      r2_q[i]   <= ge2 ? s2 - dn2_in : s2;
      dn1_q[i]  <= dn1_in;
      dn2_q[i]  <= dn2_in;
      q1_q[i]   <= {q1_in[RatioFrac-2:0], ge1};
      q2_q[i]   <= {q2_in[RatioFrac-2:0], ge2};
      base_q[i] <= base_in;
      dir1_q[i] <= dir1_in;
      dir2_q[i] <= dir2_in;
    end
  end

  assign valid_o = v_q[NS-1];
  assign ctl_o   = ctl_q[NS-1];
  assign q1_o    = q1_q[NS-1];
  assign q2_o    = q2_q[NS-1];
  assign base_o  = base_q[NS-1];
  assign dir1_o  = dir1_q[NS-1];
  assign dir2_o  = dir2_q[NS-1];

endmodule

// File: sv/cpt_combine.sv
// ----------------------------------------------------------------------------
// cpt_combine
// Point on edge or face: base + dir1*r1 + dir2*r2, floored and saturated.
// Two register stages; the second is the output register.
// ----------------------------------------------------------------------------
module cpt_combine #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  cpt_pkg::ctl_t                 ctl_i,
  input  logic [cpt_pkg::RatioFrac-1:0] q1_i,
  input  logic [cpt_pkg::RatioFrac-1:0] q2_i,
  input  logic signed [COORD_WIDTH-1:0] base_i [3],
  input  logic signed [COORD_WIDTH:0]   dir1_i [3],
  input  logic signed [COORD_WIDTH:0]   dir2_i [3],
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] point_o [3],
  output logic [2:0]                    region_o
);
  import cpt_pkg::*;

  localparam int unsigned RW = RatioFrac + 1;
  localparam int unsigned CW = COORD_WIDTH + RatioFrac + 3;
  localparam int unsigned SW = COORD_WIDTH + RatioFrac + 4;
  localparam int unsigned HW = COORD_WIDTH + 4;

  function automatic logic [RW-1:0] rsel(input ratio_mode_e m,
                                         input logic [RatioFrac-1:0] q);
    logic [RW-1:0] r;
    unique case (m)
      RM_ONE:  r = {1'b1, {RatioFrac{1'b0}}};
      RM_DIV:  r = {1'b0, q};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [RW-1:0] r1, r2;
  assign r1 = rsel(ctl_i.mode1, q1_i);
  assign r2 = rsel(ctl_i.mode2, q2_i);

  logic                  va_q;
  region_e               rega_q;
  logic signed [CW-1:0]  p1_q [3], p2_q [3];
  logic signed [COORD_WIDTH-1:0] basea_q [3];

  logic                  vo_q;
  logic [2:0]            rego_q;
  logic signed [COORD_WIDTH-1:0] pto_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vo_q <= va_q;
    end
  end

  logic signed [SW-1:0] s  [3];
  logic signed [HW-1:0] sh [3];
  logic signed [COORD_WIDTH-1:0] sat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s[k]  = (SW'(basea_q[k]) <<< RatioFrac) + SW'(p1_q[k]) + SW'(p2_q[k]);
      sh[k] = s[k][SW-1:RatioFrac];
      // out of range when the bits above the sign do not agree
      if (sh[k][HW-1:COORD_WIDTH-1] == '0 || sh[k][HW-1:COORD_WIDTH-1] == '1) begin
        sat[k] = sh[k][COORD_WIDTH-1:0];
      end else if (sh[k][HW-1]) begin
        sat[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        sat[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rega_q  <= ctl_i.region;
    basea_q <= base_i;
    for (int k = 0; k < 3; k++) begin
      p1_q[k] <= CW'(dir1_i[k]) * CW'($signed({1'b0, r1}));
      p2_q[k] <= CW'(dir2_i[k]) * CW'($signed({1'b0, r2}));
    end
    rego_q <= rega_q;
    pto_q  <= sat;
  end

  assign valid_o  = vo_q;
  assign point_o  = pto_q;
  assign region_o = rego_q;

endmodule

// File: sv/closest_point_on_triangle_unit.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle_unit
// Closest point on triangle ABC to query point P, with its region code.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the query point and the three vertices and raise start for one
//   cycle; a beat is taken at every clock edge with start high. busy is
//   always low: the pipeline takes a new beat in every cycle.
//   The result appears on closest_*_o and region_o, for one cycle with
//   done_o high.
//   Stages: 3 stages of differences and dot products, 3 of cross terms
//   (partial products, sums) and region select, 32 of divider (one quotient
//   bit per stage, two dividers side by side for the face case), 2 of
//   combine and output.
//   Throughput: one beat per cycle, set by the fully pipelined dividers.
//   Reset clears all valid bits; beats in flight are dropped.
//   The receiver cannot stall; results are never held.
//   region_o: A=0, B=1, edge AB=2, C=3, edge AC=4, edge BC=5, interior=6.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_unit #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] closest_x_o,
  output logic signed [COORD_WIDTH-1:0] closest_y_o,
  output logic signed [COORD_WIDTH-1:0] closest_z_o,
  output logic [2:0]                    region_o
);
  import cpt_pkg::*;

  localparam int unsigned W1 = COORD_WIDTH + 1;
  localparam int unsigned DW = 2 * COORD_WIDTH + 4;
  localparam int unsigned XW = 4 * COORD_WIDTH + 12;

  assign busy = 1'b0;

  logic signed [COORD_WIDTH-1:0] p_in [3], a_in [3], b_in [3], c_in [3];
  assign p_in = '{query_x_i, query_y_i, query_z_i};
  assign a_in = '{vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
  assign b_in = '{vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
  assign c_in = '{vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};

  logic                  dot_valid;
  logic signed [DW-1:0]  dot_d [6];
  logic signed [COORD_WIDTH-1:0] dot_a [3], dot_b [3], dot_c [3];
  logic signed [W1-1:0]  dot_ab [3], dot_ac [3], dot_bc [3];

  cpt_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .p_i     (p_in),
    .a_i     (a_in),
    .b_i     (b_in),
    .c_i     (c_in),
    .valid_o (dot_valid),
    .d_o     (dot_d),
    .a_o     (dot_a),
    .b_o     (dot_b),
    .c_o     (dot_c),
    .ab_o    (dot_ab),
    .ac_o    (dot_ac),
    .bc_o    (dot_bc)
  );

  logic                  reg_valid;
  ctl_t                  reg_ctl;
  logic [XW-1:0]         reg_num1, reg_den1, reg_num2, reg_den2;
  logic signed [COORD_WIDTH-1:0] reg_base [3];
  logic signed [W1-1:0]  reg_dir1 [3], reg_dir2 [3];

  cpt_region #(.COORD_WIDTH(COORD_WIDTH)) u_region (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dot_valid),
    .d_i     (dot_d),
    .a_i     (dot_a),
    .b_i     (dot_b),
    .c_i     (dot_c),
    .ab_i    (dot_ab),
    .ac_i    (dot_ac),
    .bc_i    (dot_bc),
    .valid_o (reg_valid),
    .ctl_o   (reg_ctl),
    .num1_o  (reg_num1),
    .den1_o  (reg_den1),
    .num2_o  (reg_num2),
    .den2_o  (reg_den2),
    .base_o  (reg_base),
    .dir1_o  (reg_dir1),
    .dir2_o  (reg_dir2)
  );

  logic                  div_valid;
  ctl_t                  div_ctl;
  logic [RatioFrac-1:0]  div_q1, div_q2;
  logic signed [COORD_WIDTH-1:0] div_base [3];
  logic signed [W1-1:0]  div_dir1 [3], div_dir2 [3];

  cpt_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (reg_valid),
    .ctl_i   (reg_ctl),
    .num1_i  (reg_num1),
    .den1_i  (reg_den1),
    .num2_i  (reg_num2),
    .den2_i  (reg_den2),
    .base_i  (reg_base),
    .dir1_i  (reg_dir1),
    .dir2_i  (reg_dir2),
    .valid_o (div_valid),
    .ctl_o   (div_ctl),
    .q1_o    (div_q1),
    .q2_o    (div_q2),
    .base_o  (div_base),
    .dir1_o  (div_dir1),
    .dir2_o  (div_dir2)
  );

  logic signed [COORD_WIDTH-1:0] point [3];

  cpt_combine #(.COORD_WIDTH(COORD_WIDTH)) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .ctl_i    (div_ctl),
    .q1_i     (div_q1),
    .q2_i     (div_q2),
    .base_i   (div_base),
    .dir1_i   (div_dir1),
    .dir2_i   (div_dir2),
    .valid_o  (done_o),
    .point_o  (point),
    .region_o (region_o)
  );

  assign closest_x_o = point[0];
  assign closest_y_o = point[1];
  assign closest_z_o = point[2];

  // vertex regions carry no ratio
  a_vertex_no_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && (div_ctl.region == REG_A || div_ctl.region == REG_B ||
                   div_ctl.region == REG_C))
    |-> (div_ctl.mode1 == RM_ZERO && div_ctl.mode2 == RM_ZERO))
    else $error("ratio set in a vertex region");

  // second ratio only on edge AC or the face
  a_mode2_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && div_ctl.mode2 != RM_ZERO)
    |-> (div_ctl.region == REG_AC || div_ctl.region == REG_IN))
    else $error("second ratio outside edge AC or face");

  a_done_follows_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(div_valid, 2))
    else $error("result beat without a divider beat");

  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (region_o <= REG_IN))
    else $error("region code out of range");

endmodule
